@@ hw/rtl/sine_tone_generator_top_defines.svh @@
// Assertion macros shared by the sine tone generator RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef SINE_TONE_GENERATOR_TOP_DEFINES_SVH
`define SINE_TONE_GENERATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge outside reset
`define STG_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition is followed by another in the next cycle
`define STG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define STG_ASSERT(label, clk, rst_n, prop, msg)
`define STG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ hw/rtl/stg_pkg.sv @@
// Shared types, widths and constants for the sine tone generator.
// No dependencies; imported by every RTL module of the block.
`default_nettype none

package stg_pkg;

    // Field and register widths
    localparam int RATE_W   = 18;
    localparam int AMP_W    = 15;
    localparam int TONE_W   = 16;
    localparam int SAMPLE_W = 16;
    localparam int SINE_W   = 15;
    localparam int CFG_IDX_W = 1;

    // Parameter defaults
    localparam int PHASE_BITS_DEF      = 32;
    localparam int SINE_TABLE_BITS_DEF = 10;

    // Register reset values
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);
    localparam logic [AMP_W-1:0]  AMP_RESET  = AMP_W'(3000);

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE   = 1'b1;

    // Full-scale sine magnitude
    localparam logic [SINE_W-1:0] SINE_FULL = {SINE_W{1'b1}};

    // pi/2 in Q30
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RATE,
        ST_INC
    } stg_state_t;

    // One Taylor step: term * x^2 in Q30
    function automatic logic [63:0] stg_sq_step(input logic [63:0] term, input logic [63:0] x);
        logic [63:0] t;
        t = (term * x) >> 30;
        return (t * x) >> 30;
    endfunction

    // Subtract, saturating at zero
    function automatic logic [63:0] stg_sub_sat(input logic [63:0] a, input logic [63:0] b);
        return (a >= b) ? (a - b) : 64'd0;
    endfunction

    // Quarter-wave entry: round(32767*sin(pi/2*i/2^bits)) by a Q30 Taylor series.
    // Evaluated only at elaboration to build the sine ROM.
    function automatic logic [SINE_W-1:0] sine_entry(input int unsigned idx,
                                                     input int unsigned bits);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        x    = (PI_HALF_Q30 * 64'(idx)) >> bits;
        term = x;
        sum  = x;
        term = stg_sq_step(term, x) / 64'd6;   sum = stg_sub_sat(sum, term);
        term = stg_sq_step(term, x) / 64'd20;  sum = sum + term;
        term = stg_sq_step(term, x) / 64'd42;  sum = stg_sub_sat(sum, term);
        term = stg_sq_step(term, x) / 64'd72;  sum = sum + term;
        term = stg_sq_step(term, x) / 64'd110; sum = stg_sub_sat(sum, term);
        term = stg_sq_step(term, x) / 64'd156; sum = sum + term;
        term = stg_sq_step(term, x) / 64'd210; sum = stg_sub_sat(sum, term);
        term = stg_sq_step(term, x) / 64'd272; sum = sum + term;
        term = stg_sq_step(term, x) / 64'd342; sum = stg_sub_sat(sum, term);
        term = stg_sq_step(term, x) / 64'd420; sum = sum + term;
        v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return v[SINE_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sine_tone_generator_top.sv @@
// Sine tone generator: one stereo sample per request transaction. Each result is computed
// by the shared bit-serial divider in two divisions, 18 steps for sample_rate / tone_hz and
// PHASE_BITS + 1 steps for the phase increment, and is then handed to the output register.
// A new request is accepted once the previous one has been handed to the output
// register, while that result may still wait for the sink; a sink that holds a result
// past the next handoff stalls the block until it takes it. The sine table is a
// constant ROM, so no fill pass follows reset. The user must write configuration only
// while idle; the block itself does not enforce this.
`default_nettype none

`include "sine_tone_generator_top_defines.svh"

module sine_tone_generator_top #(
    parameter int PHASE_BITS      = stg_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_BITS = stg_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Configuration write port
    input  wire logic                            cfg_we,
    input  wire logic [stg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [stg_pkg::RATE_W-1:0]      cfg_data,
    // Request stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [stg_pkg::TONE_W-1:0]      s_tdata,  // [15:0] tone_hz
    input  wire logic                            s_tlast,  // last_in_buffer
    // Sample stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [2*stg_pkg::SAMPLE_W-1:0]       m_tdata,  // [15:0] left, [31:16] right
    output logic                                 m_tlast   // frame_last
);
    import stg_pkg::*;

    localparam int DIV_W      = (PHASE_BITS + 1 > RATE_W) ? PHASE_BITS + 1 : RATE_W;
    localparam int CNT_W      = $clog2(DIV_W + 1);
    localparam int TABLE_SIZE = 1 << SINE_TABLE_BITS;
    localparam int MUL_W      = $clog2(AMP_W + 1);
    localparam logic [CNT_W-1:0] STEPS_RATE = CNT_W'(RATE_W);
    localparam logic [CNT_W-1:0] STEPS_INC  = CNT_W'(PHASE_BITS + 1);
    localparam logic [MUL_W-1:0] MUL_STEPS  = MUL_W'(AMP_W);

    typedef logic [SINE_W-1:0] rom_t [TABLE_SIZE];

    function automatic rom_t build_rom();
        rom_t r;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            r[i] = sine_entry(i, SINE_TABLE_BITS);
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // Control state
    stg_state_t              state_reg;
    stg_state_t              state_next;
    logic [PHASE_BITS-1:0]   phase_reg;
    logic [PHASE_BITS-1:0]   phase_next;
    logic [RATE_W-1:0]       rate_reg;
    logic [AMP_W-1:0]        amp_reg;
    logic                    look_reg;
    logic [MUL_W-1:0]        mul_cnt_reg;
    logic [MUL_W-1:0]        mul_cnt_next;
    logic                    out_valid_reg;

    // Payload
    logic                    last_reg;
    logic [SINE_W-1:0]       rom_q_reg;
    logic [SINE_W-1:0]       mag_reg;
    logic                    sign_reg;
    logic [2*AMP_W-1:0]      prod_reg;
    logic [2*AMP_W-1:0]      prod_next;
    logic [SAMPLE_W-1:0]     sample_reg;
    logic                    out_last_reg;

    // Datapath wires
    logic                    accept;
    logic                    out_free;
    logic                    load_out;
    logic                    div_start;
    logic                    div_busy;
    logic [DIV_W-1:0]        div_dividend;
    logic [RATE_W-1:0]       div_divisor;
    logic [CNT_W-1:0]        div_steps;
    logic [DIV_W-1:0]        div_quot;
    logic [RATE_W-1:0]       period;
    logic [TONE_W-1:0]       tone_fix;
    logic [1:0]              quad;
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [SINE_TABLE_BITS-1:0] rom_addr;
    logic [AMP_W:0]          mul_sum;
    logic [AMP_W-1:0]        scaled;
    logic [SAMPLE_W-1:0]     sample_val;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign tone_fix = (s_tdata == '0) ? TONE_W'(1) : s_tdata;
    assign period   = (div_quot[RATE_W-1:0] == '0) ? RATE_W'(1) : div_quot[RATE_W-1:0];

    // Shared bit-serial divider
    stg_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    // Sequence: rate / tone, then full turn / period, then hand off the result
    always_comb
    begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        div_start    = 1'b0;
        div_dividend = DIV_W'(rate_reg) << (DIV_W - RATE_W);
        div_divisor  = RATE_W'(tone_fix);
        div_steps    = STEPS_RATE;
        load_out     = 1'b0;
        phase_next   = phase_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    div_start  = 1'b1;
                    state_next = ST_RATE;
                end
            end
            ST_RATE:
            begin
                if (!div_busy)
                begin
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(1) << (DIV_W - 1);
                    div_divisor  = period;
                    div_steps    = STEPS_INC;
                    state_next   = ST_INC;
                end
            end
            ST_INC:
            begin
                if (!div_busy && out_free)
                begin
                    load_out   = 1'b1;
                    phase_next = phase_reg + div_quot[PHASE_BITS-1:0];
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Quadrant and index from the top of the phase; mirror odd quadrants
    assign quad     = phase_reg[PHASE_BITS-1 -: 2];
    assign idx      = phase_reg[PHASE_BITS-3 -: SINE_TABLE_BITS];
    assign rom_addr = quad[0] ? (~idx + 1'b1) : idx;

    // Serial shift-add multiply of magnitude by amplitude
    always_comb
    begin
        mul_sum      = {1'b0, prod_reg[2*AMP_W-1:AMP_W]} + (prod_reg[0] ? {1'b0, mag_reg} : '0);
        prod_next    = prod_reg;
        mul_cnt_next = mul_cnt_reg;
        if (look_reg)
        begin
            prod_next    = {{AMP_W{1'b0}}, amp_reg};
            mul_cnt_next = MUL_STEPS;
        end
        else if (mul_cnt_reg != '0)
        begin
            prod_next    = {mul_sum, prod_reg[AMP_W-1:1]};
            mul_cnt_next = mul_cnt_reg - 1'b1;
        end
    end

    assign scaled     = prod_reg[2*AMP_W-1:AMP_W];
    assign sample_val = sign_reg ? (SAMPLE_W'(0) - SAMPLE_W'(scaled)) : SAMPLE_W'(scaled);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            rate_reg      <= RATE_RESET;
            amp_reg       <= AMP_RESET;
            look_reg      <= 1'b0;
            mul_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            look_reg    <= accept;
            mul_cnt_reg <= mul_cnt_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SAMPLE_RATE: rate_reg <= cfg_data;
                    CFG_AMPLITUDE:   amp_reg  <= cfg_data[AMP_W-1:0];
                    default:         rate_reg <= rate_reg;
                endcase
            end
        end
    end

    // Sine ROM with registered read
    always_ff @(posedge clk)
    begin
        rom_q_reg <= SINE_ROM[rom_addr];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (accept)
        begin
            last_reg <= s_tlast;
        end
        if (look_reg)
        begin
            mag_reg  <= (quad[0] && (idx == '0)) ? SINE_FULL : rom_q_reg;
            sign_reg <= quad[1];
        end
        if (load_out)
        begin
            sample_reg   <= sample_val;
            out_last_reg <= last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {sample_reg, sample_reg};
    assign m_tlast  = out_last_reg;

    // Checks
    `STG_ASSERT(a_mul_done_at_load, clk, rst_n, !load_out || (mul_cnt_reg == '0 && !look_reg),
        "result loaded before the amplitude multiply finished")
    `STG_ASSERT_NEXT(a_phase_holds, clk, rst_n, !load_out, $stable(phase_reg),
        "phase moved without a result being loaded")
    `STG_ASSERT(a_div_start_idle, clk, rst_n, !div_start || !div_busy,
        "divider restarted while still stepping")
    `STG_ASSERT_NEXT(a_accept_starts, clk, rst_n, accept, state_reg == ST_RATE && div_busy,
        "accepted request did not start the rate division")
    `STG_ASSERT(a_no_overwrite, clk, rst_n, !load_out || !out_valid_reg || m_tready,
        "pending result overwritten")

endmodule

`default_nettype wire

@@ hw/rtl/stg_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on stg_pkg for the divisor width.
`default_nettype none

module stg_div #(
    parameter int DIV_W = 33
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [DIV_W-1:0]                  dividend,
    input  wire logic [stg_pkg::RATE_W-1:0]        divisor,
    input  wire logic [$clog2(DIV_W+1)-1:0]        steps,
    output logic                                   busy,
    output logic [DIV_W-1:0]                       quotient
);
    import stg_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [DIV_W-1:0]  dvd_reg;
    logic [DIV_W-1:0]  dvd_next;
    logic [RATE_W-1:0] dvs_reg;
    logic [RATE_W-1:0] dvs_next;
    logic [RATE_W-1:0] rem_reg;
    logic [RATE_W-1:0] rem_next;
    logic [RATE_W:0]   trial;
    logic [RATE_W:0]   diff;
    logic              take;

    // Shift one dividend bit into the remainder and try the subtract
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[DIV_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        take     = (trial >= {1'b0, dvs_reg});
        cnt_next = cnt_reg;
        dvd_next = dvd_reg;
        dvs_next = dvs_reg;
        rem_next = rem_reg;
        if (start)
        begin
            cnt_next = steps;
            dvd_next = dividend;
            dvs_next = divisor;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            dvd_next = {dvd_reg[DIV_W-2:0], take};
            rem_next = take ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
        end
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Dividend/quotient, divisor and partial remainder
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = dvd_reg;

endmodule

`default_nettype wire

@@ tb/sine_tone_generator_top_test.sv @@
// Self-checking testbench for sine_tone_generator_top: DDS tone requests in, stereo frames out.
// Depends on stg_pkg and the block RTL only; a built-in predictor supplies the expected frames.
module sine_tone_generator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import stg_pkg::*;

    localparam int          PHASE_W      = 32;
    localparam int          ROM_BITS     = 10;
    localparam int          ROM_LEN      = 1 << ROM_BITS;
    localparam logic [63:0] QUARTER_Q30  = 64'd1686629713;
    localparam logic [15:0] PEAK_MAG     = 16'd32767;
    localparam int          DRAIN_CYCLES = 100;

    typedef struct packed {
        logic [TONE_W-1:0] tone;
        logic              frame_end;
    } tone_req_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
        logic                frame_end;
    } stereo_frame_t;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = CFG_SAMPLE_RATE;
    logic [RATE_W-1:0]       cfg_data  = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [TONE_W-1:0]       s_tdata   = '0;   // [15:0] tone_hz
    logic                    s_tlast   = 1'b0; // last_in_buffer
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [2*SAMPLE_W-1:0]   m_tdata;          // [15:0] left, [31:16] right
    logic                    m_tlast;          // frame_last

    // Predictor state
    logic [SINE_W-1:0]       sine_rom [ROM_LEN];
    logic [PHASE_W-1:0]      phase_acc;
    logic [RATE_W-1:0]       rate_cfg;
    logic [AMP_W-1:0]        amp_cfg;

    tone_req_t               tone_reqs[$];
    stereo_frame_t           frames_due[$];
    int unsigned             idle_pct    = 0;
    int unsigned             stall_pct   = 0;
    int unsigned             mismatches  = 0;

    sine_tone_generator_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Quarter-wave magnitude by a Q30 Taylor series of sin(pi/2 * i / ROM_LEN)
    function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned i);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        int unsigned k;
        x    = (QUARTER_Q30 * 64'(i)) >> ROM_BITS;
        term = x;
        sum  = x;
        for (k = 1; k <= 10; k++)
        begin
            term = (((term * x) >> 30) * x) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                sum = (sum >= term) ? sum - term : 64'd0;
            else
                sum = sum + term;
        end
        v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
            v = 64'd32767;
        return v[SINE_W-1:0];
    endfunction

    // Produce the frame for the current phase, then advance the oscillator
    function automatic stereo_frame_t synth_frame(input logic [TONE_W-1:0] tone_hz,
                                                  input logic frame_end);
        stereo_frame_t f;
        logic [31:0]   hz;
        logic [31:0]   period;
        logic [63:0]   step;
        logic [1:0]    quad;
        logic [9:0]    idx;
        logic [15:0]   mag;
        logic [31:0]   scaled;
        logic [15:0]   val;
        hz     = (tone_hz == '0) ? 32'd1 : 32'(tone_hz);
        period = 32'(rate_cfg) / hz;
        if (period == 0)
            period = 32'd1;
        step = 64'h1_0000_0000 / 64'(period);
        quad = phase_acc[PHASE_W-1 -: 2];
        idx  = phase_acc[PHASE_W-3 -: ROM_BITS];
        if (quad[0])
            mag = (idx == '0) ? PEAK_MAG : 16'(sine_rom[~idx + 10'd1]);
        else
            mag = 16'(sine_rom[idx]);
        scaled = (32'(mag) * 32'(amp_cfg)) >> 15;
        val    = quad[1] ? -scaled[15:0] : scaled[15:0];
        f.left      = val;
        f.right     = val;
        f.frame_end = frame_end;
        phase_acc   = phase_acc + step[PHASE_W-1:0];
        return f;
    endfunction

    // Tone choice skewed toward playable periods, with some full-range and edge values
    function automatic logic [TONE_W-1:0] pick_tone();
        int unsigned r;
        int unsigned top_hz;
        int unsigned lo_hz;
        r      = $urandom_range(99);
        top_hz = rate_cfg / 2;
        if (top_hz > 65535)
            top_hz = 65535;
        if (top_hz == 0)
            top_hz = 1;
        lo_hz = (rate_cfg / 4 > 65535) ? 65535 : rate_cfg / 4;
        if (r < 65)
            return TONE_W'($urandom_range(top_hz >> $urandom_range(15), 1));
        else if (r < 80)
            return TONE_W'($urandom_range((rate_cfg > 65535) ? 65535 : rate_cfg, lo_hz));
        else if (r < 95)
            return TONE_W'($urandom_range(65535, 0));
        else
        begin
            case ($urandom_range(2))
                0:       return '0;
                1:       return '1;
                default: return TONE_W'((rate_cfg > 65535) ? 65535 : rate_cfg);
            endcase
        end
    endfunction

    task automatic push_req(input logic [TONE_W-1:0] tone, input logic frame_end);
        tone_reqs.push_back('{tone: tone, frame_end: frame_end});
    endtask

    // Queue buffer fills of random length, each closed by a marked frame; a few marks flipped
    task automatic queue_buffers(input int unsigned count);
        int unsigned n;
        int unsigned run_len;
        int unsigned j;
        logic        mark;
        n = 0;
        while (n < count)
        begin
            run_len = $urandom_range(24, 1);
            for (j = 0; j < run_len && n < count; j++)
            begin
                mark = (j == run_len - 1);
                if ($urandom_range(19) == 0)
                    mark = ~mark;
                push_req(pick_tone(), mark);
                n++;
            end
        end
    endtask

    // Hold until every request is taken and every frame has come back
    task automatic wait_idle();
        do
            @(negedge clk);
        while (tone_reqs.size() != 0 || frames_due.size() != 0 || s_tvalid);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SAMPLE_RATE)
            rate_cfg = value;
        else
            amp_cfg = value[AMP_W-1:0];
    endtask

    task automatic run_phase(input logic [RATE_W-1:0] rate, input logic [RATE_W-1:0] amp,
                             input int unsigned idle, input int unsigned stall,
                             input int unsigned count);
        wait_idle();
        write_reg(CFG_SAMPLE_RATE, rate);
        write_reg(CFG_AMPLITUDE, amp);
        idle_pct  = idle;
        stall_pct = stall;
        queue_buffers(count);
    endtask

    // Request driver: present the oldest pending tone, predict on each transaction
    always @(posedge clk)
    begin : drive_requests
        bit presenting;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            presenting = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                frames_due.push_back(synth_frame(s_tdata, s_tlast));
                void'(tone_reqs.pop_front());
                presenting = 1'b0;
            end
            if (!presenting)
            begin
                if (tone_reqs.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= tone_reqs[0].tone;
                    s_tlast  <= tone_reqs[0].frame_end;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sample monitor: stall at random, compare each frame with the oldest prediction
    always @(posedge clk)
    begin : check_frames
        stereo_frame_t due;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= stall_pct);
            if (m_tvalid && m_tready)
            begin
                if (frames_due.size() == 0)
                begin
                    $error("unexpected sample frame: left %0d right %0d last %0b",
                           $signed(m_tdata[15:0]), $signed(m_tdata[31:16]), m_tlast);
                    mismatches++;
                end
                else
                begin
                    due = frames_due.pop_front();
                    if (m_tdata[15:0] !== due.left)
                    begin
                        $error("left_sample: expected %0d, got %0d",
                               $signed(due.left), $signed(m_tdata[15:0]));
                        mismatches++;
                    end
                    if (m_tdata[31:16] !== due.right)
                    begin
                        $error("right_sample: expected %0d, got %0d",
                               $signed(due.right), $signed(m_tdata[31:16]));
                        mismatches++;
                    end
                    if (m_tlast !== due.frame_end)
                    begin
                        $error("frame_last: expected %0b, got %0b", due.frame_end, m_tlast);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        int unsigned i;
        for (i = 0; i < ROM_LEN; i++)
            sine_rom[i] = quarter_sine(i);
        phase_acc = '0;
        rate_cfg  = RATE_RESET;
        amp_cfg   = AMP_RESET;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: quarter-turn steps from zero phase hit every quadrant boundary
        for (i = 0; i < 4; i++)
            push_req(16'd12000, 1'b0);
        push_req(16'd24000, 1'b0);
        push_req(16'd24000, 1'b1);
        // Period of one holds the phase; tone above rate clamps to period one
        push_req(16'd48000, 1'b0);
        push_req(16'hFFFF, 1'b0);
        push_req(16'd47999, 1'b0);
        push_req(16'd16000, 1'b0);
        // Zero tone behaves as one hertz
        push_req(16'd0, 1'b0);
        push_req(16'd1, 1'b0);
        for (i = 0; i < 3; i++)
            push_req(16'd440, 1'b0);
        push_req(16'd1000, 1'b1);
        push_req(16'h5555, 1'b0);
        push_req(16'hAAAA, 1'b1);
        queue_buffers(180);

        // Sweep settings, extremes included, across idling styles
        run_phase(18'd192000, 18'd32767, 61, 0, 180);
        run_phase(18'd1000, 18'd0, 0, 61, 180);
        run_phase(18'd44100, 18'd16384, 16, 16, 180);
        // Zero sample rate clamps every period to one
        run_phase(18'd0, RATE_W'($urandom), 0, 0, 100);
        run_phase(18'h3FFFF, 18'd1, 61, 0, 180);
        run_phase(RATE_W'($urandom), RATE_W'($urandom), 0, 61, 180);
        run_phase(18'd8000, 18'd32767, 16, 16, 180);
        run_phase(RATE_W'($urandom_range(192000, 1000)), RATE_W'($urandom_range(32767)),
                  0, 0, 274);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog well beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/stg_pkg.sv
hw/rtl/stg_div.sv
hw/rtl/sine_tone_generator_top.sv
tb/sine_tone_generator_top_test.sv
